// ===== rtl/bec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_pkg
// Types, character codes and classification helpers shared by the bracket
// expression checker, its interfaces and its step logic.
// ----------------------------------------------------------------------------
package bec_pkg;

   localparam int CharWidth   = 8;
   localparam int StatusWidth = 3;
   localparam int StackDepth  = 3;

   typedef logic [CharWidth-1:0]   char_type;
   typedef logic [StatusWidth-1:0] status_bits_type;
   typedef logic [1:0]             rank_type;
   typedef logic [1:0]             count_type;

   // Character codes
   localparam char_type ChParenOpen   = 8'h28;  // (
   localparam char_type ChBrackOpen   = 8'h5B;  // [
   localparam char_type ChBraceOpen   = 8'h7B;  // {
   localparam char_type ChParenClose  = 8'h29;  // )
   localparam char_type ChBrackClose  = 8'h5D;  // ]
   localparam char_type ChBraceClose  = 8'h7D;  // }
   localparam char_type ChPlus        = 8'h2B;
   localparam char_type ChMinus       = 8'h2D;
   localparam char_type ChStar        = 8'h2A;
   localparam char_type ChSlash       = 8'h2F;
   localparam char_type ChDigitLow    = 8'h30;  // 0
   localparam char_type ChDigitHigh   = 8'h39;  // 9

   // Bracket ranks: braces outermost, parentheses innermost
   localparam rank_type RankNone  = 2'd0;
   localparam rank_type RankBrace = 2'd1;
   localparam rank_type RankBrack = 2'd2;
   localparam rank_type RankParen = 2'd3;

   typedef enum logic [2:0] {
      CLS_NONE  = 3'd0,
      CLS_DIGIT = 3'd1,
      CLS_OPEN  = 3'd2,
      CLS_OPER  = 3'd3,
      CLS_CLOSE = 3'd4
   } cls_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ADJ      = 3'd1,
      ST_RANK     = 3'd2,
      ST_EXTRA    = 3'd3,
      ST_MISMATCH = 3'd4,
      ST_UNCLOSED = 3'd5
   } status_type;

   // Control state carried between characters of one expression
   typedef struct packed {
      count_type  count;
      cls_type    prev_class;
      status_type fault;
   } ctl_state_type;

   // What the step logic hands back for one character
   typedef struct packed {
      ctl_state_type state_nxt;
      logic          push;
      rank_type      push_rank;
      status_type    status;
   } step_out_type;

   localparam ctl_state_type CtlReset = '{count: '0, prev_class: CLS_NONE, fault: ST_OK};

   function automatic rank_type bracket_rank(char_type c);
      rank_type r;
      r = RankNone;
      if (c == ChBraceOpen || c == ChBraceClose) begin
         r = RankBrace;
      end else if (c == ChBrackOpen || c == ChBrackClose) begin
         r = RankBrack;
      end else if (c == ChParenOpen || c == ChParenClose) begin
         r = RankParen;
      end
      return r;
   endfunction

   function automatic cls_type classify(char_type c);
      cls_type k;
      k = CLS_NONE;
      if (c >= ChDigitLow && c <= ChDigitHigh) begin
         k = CLS_DIGIT;
      end else if (c == ChParenOpen || c == ChBrackOpen || c == ChBraceOpen) begin
         k = CLS_OPEN;
      end else if (c == ChParenClose || c == ChBrackClose || c == ChBraceClose) begin
         k = CLS_CLOSE;
      end else if (c == ChPlus || c == ChMinus || c == ChStar || c == ChSlash) begin
         k = CLS_OPER;
      end
      return k;
   endfunction

   function automatic logic pair_forbidden(cls_type prev, cls_type cur);
      logic f;
      unique case (prev)
         CLS_DIGIT: f = (cur == CLS_OPEN);
         CLS_OPEN:  f = (cur == CLS_OPER) || (cur == CLS_CLOSE);
         CLS_OPER:  f = (cur == CLS_CLOSE) || (cur == CLS_OPER);
         CLS_CLOSE: f = (cur == CLS_OPEN);
         default:   f = 1'b0;
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/bec_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_req_if / bec_rsp_if
// Valid/ready channels of the checker: characters in, status beats out.
// ----------------------------------------------------------------------------
interface bec_req_if;
   import bec_pkg::*;

   logic     valid;
   logic     ready;
   char_type character;
   logic     last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

interface bec_rsp_if;
   import bec_pkg::*;

   logic            valid;
   logic            ready;
   status_bits_type status;
   logic            verdict_final;

   modport source (output valid, output status, output verdict_final, input ready);
   modport sink   (input valid, input status, input verdict_final, output ready);
endinterface

// ===== rtl/bec_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_step
// Per-character check: adjacency, bracket rank, push/pop and sticky fault,
// plus the end-of-expression verdict.
// ----------------------------------------------------------------------------
module bec_step (
   input  bec_pkg::ctl_state_type state_cur,
   input  bec_pkg::rank_type      top_rank,
   input  bec_pkg::char_type      character,
   input  logic                   last,
   output bec_pkg::step_out_type  step_out
);
   import bec_pkg::*;

   cls_type       cls;
   rank_type      rk;
   ctl_state_type nxt;
   logic          push;
   status_type    status;

   assign cls = classify(character);
   assign rk  = bracket_rank(character);

   // Character checks, skipped once a fault is latched
   always_comb begin
      nxt  = state_cur;
      push = 1'b0;
      if (state_cur.fault == ST_OK) begin
         priority if (pair_forbidden(state_cur.prev_class, cls)) begin
            nxt.fault = ST_ADJ;
         end else if (cls == CLS_OPEN) begin
            if (rk <= top_rank || state_cur.count == count_type'(StackDepth)) begin
               nxt.fault = ST_RANK;
            end else begin
               push           = 1'b1;
               nxt.count      = state_cur.count + 2'd1;
               nxt.prev_class = cls;
            end
         end else if (cls == CLS_CLOSE) begin
            if (state_cur.count == '0) begin
               nxt.fault = ST_EXTRA;
            end else begin
               nxt.count = state_cur.count - 2'd1;
               if (top_rank != rk) begin
                  nxt.fault = ST_MISMATCH;
               end else begin
                  nxt.prev_class = cls;
               end
            end
         end else begin
            nxt.prev_class = cls;
         end
      end
   end

   // Verdict and return to idle state at the end of the expression
   always_comb begin
      status            = nxt.fault;
      step_out.state_nxt = nxt;
      if (last) begin
         if (nxt.fault == ST_OK && nxt.count != '0) begin
            status = ST_UNCLOSED;
         end
         step_out.state_nxt = CtlReset;
      end
      step_out.push      = push;
      step_out.push_rank = rk;
      step_out.status    = status;
   end

endmodule

// ===== rtl/bracket_expression_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_expression_checker
// Streaming checker for bracket nesting and operator adjacency.
// ----------------------------------------------------------------------------
// One character per beat on req_bus, one status beat per character on
// rsp_bus, at a sustained rate of one character per clock while rsp_bus is
// ready. A character sits in an input register, is checked by one level of
// small logic against the open-bracket stack (three entries) and the sticky
// fault, and lands in the result register, which drives the status beat. The
// status is the first fault seen so far; on the beat marked last it is the
// verdict for the whole expression (unclosed brackets report 5) and the state
// returns to idle for the next expression. Backpressure on rsp_bus stalls the
// input register, and req_bus.ready falls only when both registers are full.
// ----------------------------------------------------------------------------
module bracket_expression_checker (
   input logic      clock,
   input logic      reset,
   bec_req_if.sink   req_bus,
   bec_rsp_if.source rsp_bus
);
   import bec_pkg::*;

   // Input register
   logic     in_valid_ff, in_valid_in;
   char_type in_char_ff;
   logic     in_last_ff;

   // Expression state
   ctl_state_type state_ff, state_in;
   rank_type      stack_ff [StackDepth];
   rank_type      top_rank;
   count_type     top_idx;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic       rsp_final_ff;

   step_out_type step_out;
   logic         rsp_free;
   logic         advance;
   logic         req_take;

   // Handshake control
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = in_valid_ff && rsp_free;
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_valid_ff || rsp_free;

   // Stack top lookup
   assign top_idx  = state_ff.count - 2'd1;
   assign top_rank = (state_ff.count == '0) ? RankNone : stack_ff[top_idx];

   bec_step u_step (
      .state_cur (state_ff),
      .top_rank  (top_rank),
      .character (in_char_ff),
      .last      (in_last_ff),
      .step_out  (step_out)
   );

   // Next-value logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = step_out.state_nxt;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      if (rsp_free) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= CtlReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers and stack
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_bus.character;
         in_last_ff <= req_bus.last;
      end
      if (advance) begin
         rsp_status_ff <= step_out.status;
         rsp_final_ff  <= in_last_ff;
         if (step_out.push) begin
            stack_ff[state_ff.count] <= step_out.push_rank;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.verdict_final = rsp_final_ff;

   // End of expression returns the state to idle
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.count == '0 && state_ff.fault == ST_OK
                                && state_ff.prev_class == CLS_NONE)
      else $error("state not cleared after last character");

   // A latched fault holds until the end of the expression
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.fault != ST_OK && !(advance && in_last_ff)
      |=> state_ff.fault == $past(state_ff.fault))
      else $error("fault code changed before end of expression");

   // A character waiting on a busy result register is never dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_free |=> in_valid_ff)
      else $error("input character lost under backpressure");

endmodule
